// ===== rtl/snapshot_block_rle_decoder_unit_macros.svh =====
// Assertion macros used by the snapshot block RLE decoder top unit.
`ifndef SNAPSHOT_BLOCK_RLE_DECODER_UNIT_MACROS_SVH
`define SNAPSHOT_BLOCK_RLE_DECODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, reset masked
`define SBRLE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked
`define SBRLE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SBRLE_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define SBRLE_ASSERT_NXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/sbrle_pkg.sv =====
// Types and constants shared by the snapshot block RLE decoder modules.
package sbrle_pkg;

    localparam int LA_DEPTH    = 3;
    localparam int MAX_RESULTS = 5;
    // four literals plus one closing status
    localparam int LOOP_STEPS  = LA_DEPTH + 2;

    localparam logic [7:0] ESC_BYTE  = 8'hED;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    typedef enum logic [2:0] {
        KIND_WRITE    = 3'd0,
        KIND_COMPLETE = 3'd1,
        KIND_MARKER   = 3'd2,
        KIND_EARLY    = 3'd3,
        KIND_BADPAGE  = 3'd4,
        KIND_HANDBACK = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        REG_COMPRESSED  = 3'd0,
        REG_END_MARKER  = 3'd1,
        REG_PAGE        = 3'd2,
        REG_MACHINE_128 = 3'd3,
        REG_BLOCK_SIZE  = 3'd4
    } reg_index_t;

    // One result as decided by the front end
    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [7:0] length;
        logic [2:0] offset;   // literal offset from the step's start position
    } entry_t;

    // All results of one accepted request
    typedef struct packed {
        logic [2:0]                  count;
        logic                        bank_flag;
        logic [2:0]                  bank;
        logic [1:0]                  base_hi;
        logic [15:0]                 position;
        entry_t [MAX_RESULTS-1:0]    ent;
    } bundle_t;

    typedef struct packed {
        logic       finished;
        logic [1:0] la_count;
    } front_status_t;

endpackage

// ===== rtl/snapshot_block_rle_decoder_unit.sv =====
// Path: results go from a queue slot register through the back end's output register.
// Throughput: one byte per cycle while each byte causes at most one result and
// m_tready stays high; a bundle's results leave one at a time, and the queue
// absorbs the rest. The back end's single output register caps results at one per cycle.
// Reset: synchronous, active low; clears decode state and loads register defaults.
`include "snapshot_block_rle_decoder_unit_macros.svh"

module snapshot_block_rle_decoder_unit import sbrle_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tuser,     // [0] end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // [0] target_is_bank, [3:1] bank_index,
                                     // [19:4] write_address, [27:20] write_value,
                                     // [35:28] run_length, [39:36] zero
    output logic [2:0]  m_tuser,     // [2:0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic          q_ready, q_push, q_valid, q_pop;
    bundle_t       q_in, q_head;
    front_status_t front_status;
    kind_t         out_kind;
    logic          out_flag;
    logic [2:0]    out_bank;
    logic [15:0]   out_addr;
    logic [7:0]    out_value, out_length;

    sbrle_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_eof    (s_tuser),
        .in_byte   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_bundle  (q_in),
        .status    (front_status)
    );

    sbrle_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    sbrle_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_valid),
        .head          (q_head),
        .pop           (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_kind      (out_kind),
        .out_bank_flag (out_flag),
        .out_bank      (out_bank),
        .out_addr      (out_addr),
        .out_value     (out_value),
        .out_length    (out_length),
        .out_last      (m_tlast)
    );

    // result packing
    assign m_tdata = {4'd0, out_length, out_value, out_addr, out_bank, out_flag};
    assign m_tuser = out_kind;

    `SBRLE_ASSERT_IMP(a_run_nonzero, aclk, aresetn, m_tvalid && (m_tuser == KIND_WRITE), m_tdata[35:28] != 8'd0, "write run with zero length")
    `SBRLE_ASSERT_IMP(a_status_clean, aclk, aresetn, m_tvalid && (m_tuser != KIND_WRITE), m_tdata[19:0] == 20'd0, "status result carries a target")
    `SBRLE_ASSERT_NXT(a_finish_sticky, aclk, aresetn, front_status.finished, front_status.finished, "finished block reopened")
    `SBRLE_ASSERT_IMP(a_finish_empty, aclk, aresetn, front_status.finished, front_status.la_count == 2'd0, "bytes held after finish")

endmodule

// ===== rtl/sbrle_front.sv =====
// Front end: config registers, lookahead state and per-byte decode into result bundles.
module sbrle_front import sbrle_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_eof,
    input  logic [7:0]    in_byte,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic          q_ready,
    output logic          q_push,
    output bundle_t       q_bundle,
    output front_status_t status
);

    // configuration
    logic        compressed_reg;
    logic        end_marker_reg;
    logic [3:0]  page_reg;
    logic        machine_reg;
    logic [15:0] block_size_reg;

    // decode state
    logic [7:0]  la_reg [LA_DEPTH];
    logic [7:0]  la_next [LA_DEPTH];
    logic [1:0]  la_cnt_reg, la_cnt_next;
    logic [16:0] consumed_reg, consumed_next;
    logic [15:0] wp_reg, wp_next;
    logic        finished_reg, finished_next;

    logic        page_ok, bank_flag;
    logic [2:0]  bank;
    logic [1:0]  base_hi;
    logic        accept;
    logic [2:0]  res_cnt;
    entry_t [MAX_RESULTS-1:0] ents;

    function automatic entry_t make_entry(kind_t k, logic [7:0] v, logic [7:0] l,
                                          logic [2:0] o);
        entry_t e;
        e.kind   = k;
        e.value  = v;
        e.length = l;
        e.offset = o;
        return e;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = q_ready;
    assign accept    = in_valid && q_ready;
    assign q_push    = accept && (res_cnt != 3'd0);

    // page to write target
    always_comb begin
        page_ok   = 1'b1;
        bank_flag = 1'b0;
        bank      = 3'd0;
        base_hi   = 2'b00;
        if (machine_reg && (page_reg >= 4'd3) && (page_reg <= 4'd10)) begin
            bank_flag = 1'b1;
            bank      = 3'(page_reg - 4'd3);
        end else begin
            case (page_reg)
                4'd0:    base_hi = 2'b00;
                4'd4:    base_hi = 2'b10;
                4'd5:    base_hi = 2'b11;
                4'd8:    base_hi = 2'b01;
                default: page_ok = 1'b0;
            endcase
        end
    end

    // unrolled decode of held bytes plus the new one
    always_comb begin : step_decode
        logic [7:0]  qb [8];
        logic [2:0]  n, h, avail, hj;
        logic [2:0]  cons_add;
        logic [7:0]  wp_add;
        logic [2:0]  r;
        logic        fin, stop, do_lit;
        logic [17:0] diff;
        logic [4:0]  full;
        logic [7:0]  b0, b1, b2, b3;

        for (int i = 0; i < 8; i++) begin
            qb[i] = 8'd0;
        end
        for (int i = 0; i < LA_DEPTH; i++) begin
            qb[i] = la_reg[i];
        end
        if (!in_eof) begin
            qb[{1'b0, la_cnt_reg}] = in_byte;
        end
        n = {1'b0, la_cnt_reg} + {2'b00, !in_eof};

        // block full after k more consumed bytes
        diff = {2'b00, block_size_reg} - {1'b0, consumed_reg};
        for (int k = 0; k < 5; k++) begin
            full[k] = $signed(diff) <= $signed(18'(k));
        end

        h        = 3'd0;
        cons_add = 3'd0;
        wp_add   = 8'd0;
        r        = 3'd0;
        fin      = finished_reg;
        stop     = 1'b0;
        avail    = 3'd0;
        hj       = 3'd0;
        do_lit   = 1'b0;
        b0 = 8'd0; b1 = 8'd0; b2 = 8'd0; b3 = 8'd0;
        ents     = '0;

        if (!finished_reg && !page_ok) begin
            ents[r] = make_entry(KIND_BADPAGE, 8'd0, 8'd0, 3'd0);
            r   = r + 3'd1;
            fin = 1'b1;
        end

        for (int it = 0; it < LOOP_STEPS; it++) begin
            if (!fin && !stop) begin
                avail = n - h;
                if (full[cons_add]) begin
                    if (r < 3'(MAX_RESULTS)) ents[r] = make_entry(KIND_COMPLETE, 8'd0, 8'd0, 3'd0);
                    r    = r + 3'd1;
                    fin  = 1'b1;
                    stop = 1'b1;
                end else if (avail == 3'd0) begin
                    if (in_eof) begin
                        if (r < 3'(MAX_RESULTS)) ents[r] = make_entry(KIND_EARLY, 8'd0, 8'd0, 3'd0);
                        r   = r + 3'd1;
                        fin = 1'b1;
                    end
                    stop = 1'b1;
                end else begin
                    do_lit = 1'b1;
                    b0 = qb[h];
                    b1 = qb[h + 3'd1];
                    b2 = qb[h + 3'd2];
                    b3 = qb[h + 3'd3];
                    if (compressed_reg) begin
                        if (b0 == ESC_BYTE) begin
                            if ((avail < 3'd2) && !in_eof) begin
                                do_lit = 1'b0;
                                stop   = 1'b1;
                            end else if ((avail >= 3'd2) && (b1 == ESC_BYTE)) begin
                                do_lit = 1'b0;
                                if (avail < 3'd4) begin
                                    // unfinished run: wait, or drop it at end of file
                                    stop = 1'b1;
                                    if (in_eof) begin
                                        if (r < 3'(MAX_RESULTS)) begin
                                            ents[r] = make_entry(KIND_EARLY, 8'd0, 8'd0, 3'd0);
                                        end
                                        r   = r + 3'd1;
                                        fin = 1'b1;
                                        h   = n;
                                    end
                                end else begin
                                    // full run; a zero count writes nothing
                                    if (b2 != 8'd0) begin
                                        if (r < 3'(MAX_RESULTS)) begin
                                            ents[r] = make_entry(KIND_WRITE, b3, b2, wp_add[2:0]);
                                        end
                                        r = r + 3'd1;
                                    end
                                    wp_add   = wp_add + b2;
                                    cons_add = cons_add + 3'd4;
                                    h        = h + 3'd4;
                                end
                            end
                        end else if (end_marker_reg && (b0 == ZERO_BYTE)) begin
                            if ((avail < 3'd2) && !in_eof) begin
                                do_lit = 1'b0;
                                stop   = 1'b1;
                            end else if ((avail >= 3'd2) && (b1 == ESC_BYTE)) begin
                                if (avail < 3'd4) begin
                                    if (!in_eof) begin
                                        do_lit = 1'b0;
                                        stop   = 1'b1;
                                    end
                                end else if ((b2 == ESC_BYTE) && (b3 == ZERO_BYTE)) begin
                                    do_lit = 1'b0;
                                    if (r < 3'(MAX_RESULTS)) begin
                                        ents[r] = make_entry(KIND_MARKER, 8'd0, 8'd0, 3'd0);
                                    end
                                    r    = r + 3'd1;
                                    fin  = 1'b1;
                                    stop = 1'b1;
                                    h    = h + 3'd4;
                                end
                            end
                        end
                    end
                    if (do_lit) begin
                        if (r < 3'(MAX_RESULTS)) ents[r] = make_entry(KIND_WRITE, b0, 8'd1, wp_add[2:0]);
                        r        = r + 3'd1;
                        wp_add   = wp_add + 8'd1;
                        cons_add = cons_add + 3'd1;
                        h        = h + 3'd1;
                    end
                end
            end
        end

        // hand back what is left once finished, otherwise keep it
        for (int j = 0; j < LA_DEPTH + 1; j++) begin
            hj = h + 3'(j);
            if (fin && (hj < n)) begin
                if (r < 3'(MAX_RESULTS)) ents[r] = make_entry(KIND_HANDBACK, qb[hj], 8'd0, 3'd0);
                r = r + 3'd1;
            end
        end
        for (int i = 0; i < LA_DEPTH; i++) begin
            hj = h + 3'(i);
            la_next[i] = (!fin && (hj < n)) ? qb[hj] : 8'd0;
        end
        la_cnt_next   = fin ? 2'd0 : 2'(n - h);
        consumed_next = consumed_reg + {14'd0, cons_add};
        wp_next       = wp_reg + {8'd0, wp_add};
        finished_next = fin;
        res_cnt       = r;
    end

    always_comb begin
        q_bundle.count     = res_cnt;
        q_bundle.bank_flag = bank_flag;
        q_bundle.bank      = bank;
        q_bundle.base_hi   = base_hi;
        q_bundle.position  = wp_reg;
        q_bundle.ent       = ents;
    end

    assign status.finished = finished_reg;
    assign status.la_count = la_cnt_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compressed_reg <= 1'b1;
            end_marker_reg <= 1'b0;
            page_reg       <= 4'd8;
            machine_reg    <= 1'b0;
            block_size_reg <= 16'd16384;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_COMPRESSED:  compressed_reg <= cfg_data[0];
                REG_END_MARKER:  end_marker_reg <= cfg_data[0];
                REG_PAGE:        page_reg       <= cfg_data[3:0];
                REG_MACHINE_128: machine_reg    <= cfg_data[0];
                REG_BLOCK_SIZE:  block_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // decode state update per accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LA_DEPTH; i++) begin
                la_reg[i] <= 8'd0;
            end
            la_cnt_reg   <= 2'd0;
            consumed_reg <= 17'd0;
            wp_reg       <= 16'd0;
            finished_reg <= 1'b0;
        end else if (accept) begin
            for (int i = 0; i < LA_DEPTH; i++) begin
                la_reg[i] <= la_next[i];
            end
            la_cnt_reg   <= la_cnt_next;
            consumed_reg <= consumed_next;
            wp_reg       <= wp_next;
            finished_reg <= finished_next;
        end
    end

endmodule

// ===== rtl/sbrle_queue.sv =====
// Short bundle queue between front end and back end.
module sbrle_queue import sbrle_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    ready,
    input  logic    pop,
    output logic    valid,
    output bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign ready = (count_reg != CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    // pointer and fill tracking
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/sbrle_back.sv =====
// Back end: serialises each bundle into result requests through an output register.
module sbrle_back import sbrle_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  bundle_t     head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output kind_t       out_kind,
    output logic        out_bank_flag,
    output logic [2:0]  out_bank,
    output logic [15:0] out_addr,
    output logic [7:0]  out_value,
    output logic [7:0]  out_length,
    output logic        out_last
);

    logic [2:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    kind_t       kind_reg;
    logic        flag_reg;
    logic [2:0]  bank_reg;
    logic [15:0] addr_reg;
    logic [7:0]  value_reg, length_reg;
    logic        last_reg;

    entry_t      cur;
    logic        is_last, load, is_write;
    logic [15:0] addr_calc;

    assign cur       = head.ent[idx_reg];
    assign is_last   = (idx_reg == (head.count - 3'd1));
    assign load      = head_valid && (!valid_reg || out_ready);
    assign pop       = load && is_last;
    assign is_write  = (cur.kind == KIND_WRITE);
    assign addr_calc = {head.base_hi, 14'd0} + head.position + {13'd0, cur.offset};

    // entry index and output valid
    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload; target fields only for writes
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= cur.kind;
            flag_reg   <= is_write ? head.bank_flag : 1'b0;
            bank_reg   <= is_write ? head.bank : 3'd0;
            addr_reg   <= is_write ? addr_calc : 16'd0;
            value_reg  <= cur.value;
            length_reg <= cur.length;
            last_reg   <= is_last;
        end
    end

    assign out_valid     = valid_reg;
    assign out_kind      = kind_reg;
    assign out_bank_flag = flag_reg;
    assign out_bank      = bank_reg;
    assign out_addr      = addr_reg;
    assign out_value     = value_reg;
    assign out_length    = length_reg;
    assign out_last      = last_reg;

endmodule

// ===== dv/sbrle_tb_pkg.sv =====
// Scoreboard with the expected-result model for the snapshot block RLE decoder bench.
package sbrle_tb_pkg;
    import sbrle_pkg::*;

    localparam logic [15:0] BASE_PAGE0 = 16'h0000;
    localparam logic [15:0] BASE_PAGE4 = 16'h8000;
    localparam logic [15:0] BASE_PAGE5 = 16'hC000;
    localparam logic [15:0] BASE_PAGE8 = 16'h4000;
    localparam int          MAX_REPORTS = 10;

    // One result as seen on the master side
    typedef struct packed {
        kind_t       kind;
        logic        bank_flag;
        logic [2:0]  bank;
        logic [15:0] addr;
        logic [7:0]  value;
        logic [7:0]  len;
        logic        last;
    } rle_result_t;

    class rle_scoreboard;
        // register copy
        bit          cmp;
        bit          em;
        bit          m128;
        logic [3:0]  page;
        logic [15:0] bsize;
        // decoder state copy
        logic [7:0]  la [0:2];
        int          la_n;
        logic [16:0] consumed;
        logic [15:0] wpos;
        bit          finished;

        rle_result_t expected_q[$];
        rle_result_t step_q[$];
        int          errors;
        int          results_seen;
        int          requests_seen;

        function new();
            cmp = 1'b1;
            em = 1'b0;
            page = 4'd8;
            m128 = 1'b0;
            bsize = 16'd16384;
            for (int i = 0; i < LA_DEPTH; i++) la[i] = '0;
            la_n = 0;
            consumed = '0;
            wpos = '0;
            finished = 1'b0;
            errors = 0;
            results_seen = 0;
            requests_seen = 0;
        endfunction

        function void set_register(reg_index_t idx, logic [15:0] d);
            case (idx)
                REG_COMPRESSED:  cmp = d[0];
                REG_END_MARKER:  em = d[0];
                REG_PAGE:        page = d[3:0];
                REG_MACHINE_128: m128 = d[0];
                REG_BLOCK_SIZE:  bsize = d;
                default: ;
            endcase
        endfunction

        // Write target of the current page; 0 when the page is unsupported
        function bit page_target(output bit bf, output logic [2:0] bk,
                                 output logic [15:0] base);
            bf = 1'b0;
            bk = '0;
            base = BASE_PAGE0;
            if (m128 && page >= 4'd3 && page <= 4'd10) begin
                bf = 1'b1;
                bk = 3'(page - 4'd3);
                return 1'b1;
            end
            case (page)
                4'd0: base = BASE_PAGE0;
                4'd4: base = BASE_PAGE4;
                4'd5: base = BASE_PAGE5;
                4'd8: base = BASE_PAGE8;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void emit(kind_t k, bit bf, logic [2:0] bk, logic [15:0] a,
                           logic [7:0] v, logic [7:0] l);
            rle_result_t r;
            r.kind = k;
            r.bank_flag = bf;
            r.bank = bk;
            r.addr = a;
            r.value = v;
            r.len = l;
            r.last = 1'b0;
            step_q.push_back(r);
        endfunction

        // Work out every result that one accepted request causes
        function void note_request(bit eof, logic [7:0] din);
            logic [7:0]  q [0:3];
            int          n;
            int          h;
            int          avail;
            int          i;
            bit          bf;
            logic [2:0]  bk;
            logic [15:0] base;
            logic [7:0]  b0;
            n = 0;
            h = 0;
            requests_seen++;
            step_q.delete();
            for (i = 0; i < la_n; i++) begin
                q[n] = la[i];
                n++;
            end
            if (!eof) begin
                q[n] = din;
                n++;
            end

            if (!finished) begin
                if (!page_target(bf, bk, base)) begin
                    emit(KIND_BADPAGE, 0, '0, '0, '0, '0);
                    finished = 1'b1;
                end
                while (!finished) begin
                    avail = n - h;
                    if (consumed >= {1'b0, bsize}) begin
                        emit(KIND_COMPLETE, 0, '0, '0, '0, '0);
                        finished = 1'b1;
                        break;
                    end
                    if (avail == 0) begin
                        if (eof) begin
                            emit(KIND_EARLY, 0, '0, '0, '0, '0);
                            finished = 1'b1;
                        end
                        break;
                    end
                    b0 = q[h];
                    if (cmp) begin
                        if (b0 == ESC_BYTE) begin
                            if (avail < 2 && !eof) break;
                            if (avail >= 2 && q[h+1] == ESC_BYTE) begin
                                // ED ED count value; an unfinished run at end of file is dropped
                                if (avail < 4) begin
                                    if (!eof) break;
                                    emit(KIND_EARLY, 0, '0, '0, '0, '0);
                                    finished = 1'b1;
                                    h = n;
                                    break;
                                end
                                if (q[h+2] != 8'd0)
                                    emit(KIND_WRITE, bf, bk, base + wpos, q[h+3], q[h+2]);
                                wpos = wpos + 16'(q[h+2]);
                                consumed = consumed + 17'd4;
                                h += 4;
                                continue;
                            end
                        end else if (em && b0 == ZERO_BYTE) begin
                            if (avail < 2 && !eof) break;
                            if (avail >= 2 && q[h+1] == ESC_BYTE) begin
                                if (avail < 4) begin
                                    if (!eof) break;
                                end else if (q[h+2] == ESC_BYTE && q[h+3] == ZERO_BYTE) begin
                                    emit(KIND_MARKER, 0, '0, '0, '0, '0);
                                    finished = 1'b1;
                                    h += 4;
                                    break;
                                end
                            end
                        end
                    end
                    // plain literal
                    emit(KIND_WRITE, bf, bk, base + wpos, b0, 8'd1);
                    wpos = wpos + 16'd1;
                    consumed = consumed + 17'd1;
                    h++;
                end
            end

            for (i = 0; i < LA_DEPTH; i++) la[i] = '0;
            la_n = 0;
            if (finished) begin
                // everything unused goes back
                while (h < n) begin
                    emit(KIND_HANDBACK, 0, '0, '0, q[h], '0);
                    h++;
                end
            end else begin
                while (h < n && la_n < LA_DEPTH) begin
                    la[la_n] = q[h];
                    la_n++;
                    h++;
                end
            end

            if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
            foreach (step_q[j]) expected_q.push_back(step_q[j]);
        endfunction

        function void report(string why, rle_result_t want, rle_result_t got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("MISMATCH %s: want kind=%0d bank=%0d/%0d addr=%h val=%h len=%0d last=%0d, got kind=%0d bank=%0d/%0d addr=%h val=%h len=%0d last=%0d",
                         why, want.kind, want.bank_flag, want.bank, want.addr, want.value,
                         want.len, want.last, got.kind, got.bank_flag, got.bank, got.addr,
                         got.value, got.len, got.last);
        endfunction

        // Compare one result against the oldest outstanding expectation
        function void check_result(rle_result_t got);
            rle_result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report("unexpected", got, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.bank_flag !== want.bank_flag ||
                got.bank !== want.bank || got.addr !== want.addr ||
                got.value !== want.value || got.len !== want.len ||
                got.last !== want.last)
                report("field", want, got);
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
// Top-level testbench for the snapshot block RLE decoder: stimulus, checking and run control.
module tb_top;
    import sbrle_pkg::*;
    import sbrle_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 36;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    rle_scoreboard sb = new();

    int          cycles = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    bit          no_idle = 1'b0;
    logic [23:0] hist = '0;
    logic [15:0] rdy_pat = 16'hFFFF;
    int          rdy_tick = 0;

    snapshot_block_rle_decoder_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver stalls on a rotating 16-bit pattern, reloaded with a random choice
    always @(negedge aclk) begin
        rdy_tick++;
        if (rdy_tick % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: rdy_pat = 16'hFFFF;
                1: rdy_pat = 16'($urandom);
                2: rdy_pat = 16'($urandom) | 16'($urandom);
                default: rdy_pat = 16'h00FF;
            endcase
        end
        m_tready = rdy_pat[0];
        rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
    end

    // Sample every handshake at the rising edge
    always @(posedge aclk) begin
        rle_result_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_register(reg_index_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got.kind = kind_t'(m_tuser);
                got.bank_flag = m_tdata[0];
                got.bank = m_tdata[3:1];
                got.addr = m_tdata[19:4];
                got.value = m_tdata[27:20];
                got.len = m_tdata[35:28];
                got.last = m_tlast;
                sb.check_result(got);
            end
        end
    end

    // One input request, with bursts and random gaps in front
    task automatic send_item(input bit eof, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = eof;
        s_tdata = b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Data byte, kept from forming an accidental block-end marker
    task automatic send_data(input logic [7:0] b);
        if (sb.em && hist == {ZERO_BYTE, ESC_BYTE, ESC_BYTE} && b == ZERO_BYTE)
            b = 8'h01;
        hist = {hist[15:0], b};
        send_item(1'b0, b);
    endtask

    task automatic write_cfg(input reg_index_t idx, input logic [15:0] d);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setting(input bit c, input bit e, input logic [3:0] p,
                                 input bit m, input logic [15:0] bs);
        write_cfg(REG_COMPRESSED, 16'(c));
        write_cfg(REG_END_MARKER, 16'(e));
        write_cfg(REG_PAGE, 16'(p));
        write_cfg(REG_MACHINE_128, 16'(m));
        write_cfg(REG_BLOCK_SIZE, bs);
    endtask

    // Sender stops until every expected result has arrived, then the pipe drains
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        burst_left = 0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One token of the byte stream: mostly well-formed, some noise
    task automatic gen_token();
        int          r;
        int          k;
        logic [7:0]  b;
        logic [7:0]  cnt;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            b = 8'($urandom_range(0, 255));
            if (b == ESC_BYTE && $urandom_range(0, 3) != 0) b = 8'h11;
            send_data(b);
        end else if (r < 70) begin
            case ($urandom_range(0, 7))
                0: cnt = 8'd0;
                1: cnt = 8'hFF;
                2: cnt = 8'd1;
                default: cnt = 8'($urandom_range(2, 254));
            endcase
            send_data(ESC_BYTE);
            send_data(ESC_BYTE);
            send_data(cnt);
            send_data(8'($urandom_range(0, 255)));
        end else if (r < 80) begin
            send_data(ESC_BYTE);
            b = 8'($urandom_range(0, 255));
            if (b == ESC_BYTE) b = 8'h00;
            send_data(b);
        end else if (r < 90) begin
            send_data(ZERO_BYTE);
            send_data(ESC_BYTE);
            send_data(($urandom_range(0, 1) != 0) ? ESC_BYTE : 8'($urandom_range(0, 255)));
            send_data(8'($urandom_range(0, 255)));
        end else begin
            // broken fragments
            k = $urandom_range(1, 4);
            repeat (k) begin
                case ($urandom_range(0, 2))
                    0: b = ESC_BYTE;
                    1: b = ZERO_BYTE;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_data(b);
            end
        end
    endtask

    initial begin
        logic [7:0]  dir_a[$];
        logic [7:0]  dir_b[$];
        int          ph;
        int          k;
        int          target;
        int          term;
        bit          paused;
        bit          c;
        bit          e;
        bit          m;
        logic [3:0]  pg;
        logic [15:0] bs;
        string       term_name;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        paused = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: literals, runs incl. zero and full count, lone escape
        dir_a = '{8'h00, 8'hFF, 8'hED, 8'hED, 8'h05, 8'hAA, 8'hED, 8'hED, 8'hFF, 8'h00,
                  8'hED, 8'hED, 8'h00, 8'h55, 8'hED, 8'h12};
        apply_setting(1'b1, 1'b0, 4'd8, 1'b0, 16'hFFFF);
        foreach (dir_a[i]) send_data(dir_a[i]);
        settle();

        // Directed: zero-escape prefixes that are not a block end, top RAM bank
        dir_b = '{8'h00, 8'hED, 8'h01, 8'h02, 8'h00, 8'hED, 8'hED, 8'h01, 8'h33};
        apply_setting(1'b1, 1'b1, 4'd10, 1'b1, 16'hFFFF);
        foreach (dir_b[i]) send_data(dir_b[i]);

        // Random phases, each under a fresh valid setting
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            m = 1'($urandom_range(0, 1));
            if (m) begin
                k = $urandom_range(0, 8);
                pg = (k == 0) ? 4'd0 : 4'(k + 2);
            end else begin
                case ($urandom_range(0, 3))
                    0: pg = 4'd0;
                    1: pg = 4'd4;
                    2: pg = 4'd5;
                    default: pg = 4'd8;
                endcase
            end
            c = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            e = 1'($urandom_range(0, 1));
            bs = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(1024, 65535));
            apply_setting(c, e, pg, m, bs);
            no_idle = (ph == 2);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                gen_token();
                if (ph == 3 && !paused && items_sent >= target - 22) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end
        no_idle = 1'b0;

        // Bytes that may still be held when the block ends
        case ($urandom_range(0, 3))
            0: ;
            1: send_data(ESC_BYTE);
            2: begin
                send_data(ESC_BYTE);
                send_data(ESC_BYTE);
            end
            default: begin
                send_data(ESC_BYTE);
                send_data(ESC_BYTE);
                send_data(8'h07);
            end
        endcase
        settle();

        // Finish the block one way
        term = $urandom_range(0, 4);
        case (term)
            0: begin
                term_name = "empty block size";
                write_cfg(REG_BLOCK_SIZE, 16'd0);
                repeat (3) gen_token();
            end
            1: begin
                term_name = "block full";
                write_cfg(REG_BLOCK_SIZE, 16'(sb.consumed) + 16'($urandom_range(0, 5)));
                k = 0;
                while (!sb.finished && k < 10) begin
                    gen_token();
                    k++;
                end
            end
            2: begin
                term_name = "bad page";
                m = 1'($urandom_range(0, 1));
                write_cfg(REG_MACHINE_128, 16'(m));
                write_cfg(REG_PAGE, ($urandom_range(0, 1) != 0) ? 16'd15 : 16'd1);
                repeat (2) gen_token();
            end
            3: term_name = "end of file";
            default: begin
                term_name = "end marker";
                write_cfg(REG_COMPRESSED, 16'd1);
                write_cfg(REG_END_MARKER, 16'd1);
                send_item(1'b0, ZERO_BYTE);
                send_item(1'b0, ESC_BYTE);
                send_item(1'b0, ESC_BYTE);
                send_item(1'b0, ZERO_BYTE);
            end
        endcase
        send_item(1'b1, 8'($urandom_range(0, 255)));
        settle();

        // Finished block: bytes come back, end of file is silent
        apply_setting(1'b0, 1'b0, 4'd15, 1'b0, 16'd0);
        repeat (20) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

        // Drain and finish
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES * 2) @(posedge aclk);
        if (sb.expected_q.size() != 0) begin
            $display("%0d expected results never arrived", sb.expected_q.size());
            sb.errors += sb.expected_q.size();
        end

        $display("Run covered %0d requests and %0d results over %0d random settings,",
                 sb.requests_seen, sb.results_seen, RANDOM_PHASES);
        $display("block ended by %s; %0d mismatches.", term_name, sb.errors);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
